/* sv/radix_digit_calculator_defines.svh */
// ----------------------------------------------------------------------------
// radix_digit_calculator_defines
// Assertion macros for the radix digit calculator.
// ----------------------------------------------------------------------------
`ifndef RADIX_DIGIT_CALCULATOR_DEFINES_SVH
`define RADIX_DIGIT_CALCULATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// clocked check, idle while reset is low
`define RDC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check, also active during reset
`define RDC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RDC_ASSERT(lbl, clk, rst_n, prop, msg)
`define RDC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* sv/rdc_pkg.sv */
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared types, codes and helper functions of the radix digit calculator.
// ----------------------------------------------------------------------------
package rdc_pkg;

    localparam int OP_W         = 30;   // operand text and binary operand width
    localparam int DIV_W        = 60;   // answer, product and dividend width
    localparam int DIGIT_W      = 4;
    localparam int NARROW_STEPS = 6;    // quotient bits per cycle, small divisor
    localparam int NARROW_CYC   = DIV_W / NARROW_STEPS;
    localparam int WIDE_CYC     = OP_W;
    localparam int CNT_W        = $clog2(WIDE_CYC + 1);

    localparam int IN_DIGITS_DEF  = 9;
    localparam int OUT_DIGITS_DEF = 18;

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_SUB = 2'd1;
    localparam logic [1:0] CMD_MUL = 2'd2;
    localparam logic [1:0] CMD_DIV = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_BASE  = 3'd1;
    localparam logic [2:0] ST_BAD_DIGIT = 3'd2;
    localparam logic [2:0] ST_DIV_ZERO  = 3'd3;
    localparam logic [2:0] ST_NEGATIVE  = 3'd4;
    localparam logic [2:0] ST_OVERFLOW  = 3'd5;

    localparam logic [DIGIT_W-1:0] BASE_MIN = 4'd2;
    localparam logic [DIGIT_W-1:0] BASE_MAX = 4'd10;
    localparam logic [DIGIT_W-1:0] TEN      = 4'd10;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [3:0]         in_base;
        logic [OP_W-1:0]    first_operand;
        logic [OP_W-1:0]    second_operand;
        logic [3:0]         out_base;
    } t_in_word;

    typedef struct packed {
        logic [DIV_W-1:0]   answer;
        logic [2:0]         status;
    } t_out_word;

    typedef struct packed {
        logic start;
        logic narrow;
    } t_div_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    function automatic logic [63:0] pow10(input int n);
        logic [63:0] acc;
        acc = 64'd1;
        for (int i = 0; i < n; i++) acc = acc * 64'd10;
        return acc;
    endfunction

    function automatic logic [63:0] repunit(input int n);
        logic [63:0] acc;
        acc = 64'd0;
        for (int i = 0; i < n; i++) acc = acc * 64'd10 + 64'd1;
        return acc;
    endfunction

    // small digit times a wide value, as shift and add
    function automatic logic [DIV_W-1:0] mul_digit(input logic [DIGIT_W-1:0] d,
                                                   input logic [DIV_W-1:0] x);
        logic [DIV_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < DIGIT_W; i++) begin
            if (d[i]) acc = acc + (x << i);
        end
        return acc;
    endfunction

endpackage

/* sv/radix_digit_calculator.sv */
// ----------------------------------------------------------------------------
// radix_digit_calculator
// Checks two operands in a base from 2 to 10, converts them to binary, adds,
// subtracts, multiplies or divides them and writes the answer in the output
// base, with a status code.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                  | word
//  --------+-----------+----------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_in_data  (t_in_word)
//  out     | output    | o_out_valid / i_out_ready  | o_out_data (t_out_word)
//
// One word at a time. Each operand digit takes the shared divider by ten,
// then a test and accumulate; each answer digit takes the divider by
// out_base; a divide command first runs the divider in its one-bit-per-cycle
// mode and then collects the quotient. Base and digit errors end early.
// Reset is synchronous, active low, and leaves the block idle and empty.
// A finished word sits in the output register; a new input word is taken
// meanwhile, and its result waits in the done state until the register frees.
`include "radix_digit_calculator_defines.svh"

module radix_digit_calculator
    import rdc_pkg::*;
#(
    parameter int IN_DIGITS  = IN_DIGITS_DEF,
    parameter int OUT_DIGITS = OUT_DIGITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_data
);

    localparam int N_W = $clog2(OUT_DIGITS + 1);
    // operand text must stay below ten to the power of the digit count
    localparam logic [DIV_W-1:0] IN_LIMIT = DIV_W'(pow10(IN_DIGITS));
    // all-ones in decimal digits; times (base - 1) gives the saturated answer
    localparam logic [DIV_W-1:0] REPUNIT  = DIV_W'(repunit(OUT_DIGITS));

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_CHECK    = 9'b000000010,
        S_IN_TEST  = 9'b000000100,
        S_IN_DIV   = 9'b000001000,
        S_ARITH    = 9'b000010000,
        S_QDIV     = 9'b000100000,
        S_OUT_TEST = 9'b001000000,
        S_OUT_DIV  = 9'b010000000,
        S_DONE     = 9'b100000000
    } t_state;

    t_state           r_state, n_state;
    t_in_word         r_req, n_req;
    logic             r_opsel, n_opsel;
    logic [OP_W-1:0]  r_text, n_text;
    logic [OP_W-1:0]  r_place_in, n_place_in;
    logic [OP_W-1:0]  r_acc_in, n_acc_in;
    logic [OP_W-1:0]  r_a, n_a;
    logic [OP_W-1:0]  r_b, n_b;
    logic [DIV_W-1:0] r_v, n_v;
    logic [DIV_W-1:0] r_place_out, n_place_out;
    logic [DIV_W-1:0] r_acc_out, n_acc_out;
    logic [N_W-1:0]   r_n, n_n;
    logic [2:0]       r_status, n_status;
    logic [DIV_W-1:0] r_answer, n_answer;
    logic             r_out_valid, n_out_valid;
    t_out_word        r_out_word, n_out_word;

    t_div_ctrl        div_ctrl;
    t_div_stat        div_stat;
    logic [DIV_W-1:0] div_dividend;
    logic [OP_W-1:0]  div_divisor;
    logic [DIV_W-1:0] div_quo;
    logic [OP_W-1:0]  div_rem;

    logic             bases_ok;
    logic             digits_fit;
    logic [DIGIT_W-1:0] ob_m1;

    rdc_divider u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (div_ctrl),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_stat      (div_stat),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    assign bases_ok   = (r_req.in_base >= BASE_MIN) && (r_req.in_base <= BASE_MAX) &&
                        (r_req.out_base >= BASE_MIN) && (r_req.out_base <= BASE_MAX);
    assign digits_fit = (DIV_W'(r_req.first_operand) < IN_LIMIT) &&
                        (DIV_W'(r_req.second_operand) < IN_LIMIT);
    assign ob_m1      = r_req.out_base - DIGIT_W'(1);

    always_comb begin
        logic [DIGIT_W-1:0] dig;
        n_state     = r_state;
        n_req       = r_req;
        n_opsel     = r_opsel;
        n_text      = r_text;
        n_place_in  = r_place_in;
        n_acc_in    = r_acc_in;
        n_a         = r_a;
        n_b         = r_b;
        n_v         = r_v;
        n_place_out = r_place_out;
        n_acc_out   = r_acc_out;
        n_n         = r_n;
        n_status    = r_status;
        n_answer    = r_answer;
        // drop the held word once the consumer takes it
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_word  = r_out_word;
        div_ctrl     = '0;
        div_dividend = '0;
        div_divisor  = '0;
        dig          = div_rem[DIGIT_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in_data;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!bases_ok) begin
                    n_status = ST_BAD_BASE;
                    n_answer = '0;
                    n_state  = S_DONE;
                end else if (!digits_fit) begin
                    n_status = ST_BAD_DIGIT;
                    n_answer = '0;
                    n_state  = S_DONE;
                end else begin
                    n_text     = r_req.first_operand;
                    n_place_in = OP_W'(1);
                    n_acc_in   = '0;
                    n_opsel    = 1'b0;
                    n_state    = S_IN_TEST;
                end
            end
            S_IN_TEST: begin
                if (r_text == '0) begin
                    // operand finished: store it, then move on to the next one
                    if (!r_opsel) begin
                        n_a        = r_acc_in;
                        n_text     = r_req.second_operand;
                        n_place_in = OP_W'(1);
                        n_acc_in   = '0;
                        n_opsel    = 1'b1;
                    end else begin
                        n_b     = r_acc_in;
                        n_state = S_ARITH;
                    end
                end else begin
                    // peel off the lowest decimal digit
                    div_ctrl.start  = 1'b1;
                    div_ctrl.narrow = 1'b1;
                    div_dividend    = DIV_W'(r_text);
                    div_divisor     = OP_W'(TEN);
                    n_state         = S_IN_DIV;
                end
            end
            S_IN_DIV: begin
                if (div_stat.done) begin
                    if (dig >= r_req.in_base) begin
                        n_status = ST_BAD_DIGIT;
                        n_answer = '0;
                        n_state  = S_DONE;
                    end else begin
                        n_acc_in   = r_acc_in +
                                     OP_W'(mul_digit(dig, DIV_W'(r_place_in)));
                        n_place_in = OP_W'(mul_digit(r_req.in_base, DIV_W'(r_place_in)));
                        n_text     = div_quo[OP_W-1:0];
                        n_state    = S_IN_TEST;
                    end
                end
            end
            S_ARITH: begin
                n_n         = '0;
                n_place_out = DIV_W'(1);
                n_acc_out   = '0;
                n_state     = S_OUT_TEST;
                case (r_req.cmd)
                    CMD_ADD: n_v = DIV_W'(r_a) + DIV_W'(r_b);
                    CMD_SUB: begin
                        if (r_a < r_b) begin
                            n_status = ST_NEGATIVE;
                            n_answer = '0;
                            n_state  = S_DONE;
                        end else begin
                            n_v = DIV_W'(r_a - r_b);
                        end
                    end
                    CMD_MUL: n_v = DIV_W'(r_a) * DIV_W'(r_b);
                    default: begin
                        if (r_b == '0) begin
                            n_status = ST_DIV_ZERO;
                            n_answer = '0;
                            n_state  = S_DONE;
                        end else begin
                            // dividend in the top half: quotient lands in the low bits
                            div_ctrl.start  = 1'b1;
                            div_ctrl.narrow = 1'b0;
                            div_dividend    = {r_a, {(DIV_W-OP_W){1'b0}}};
                            div_divisor     = r_b;
                            n_state         = S_QDIV;
                        end
                    end
                endcase
            end
            S_QDIV: begin
                if (div_stat.done) begin
                    n_v     = div_quo;
                    n_state = S_OUT_TEST;
                end
            end
            S_OUT_TEST: begin
                if (r_v == '0) begin
                    n_status = ST_OK;
                    n_answer = r_acc_out;
                    n_state  = S_DONE;
                end else if (r_n == N_W'(OUT_DIGITS)) begin
                    n_status = ST_OVERFLOW;
                    n_answer = mul_digit(ob_m1, REPUNIT);
                    n_state  = S_DONE;
                end else begin
                    div_ctrl.start  = 1'b1;
                    div_ctrl.narrow = 1'b1;
                    div_dividend    = r_v;
                    div_divisor     = OP_W'(r_req.out_base);
                    n_state         = S_OUT_DIV;
                end
            end
            S_OUT_DIV: begin
                if (div_stat.done) begin
                    n_acc_out   = r_acc_out + mul_digit(dig, r_place_out);
                    n_place_out = (r_place_out << 3) + (r_place_out << 1);
                    n_v         = div_quo;
                    n_n         = r_n + N_W'(1);
                    n_state     = S_OUT_TEST;
                end
            end
            S_DONE: begin
                // hold the result until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid        = 1'b1;
                    n_out_word.answer  = r_answer;
                    n_out_word.status  = r_status;
                    n_state            = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_req       <= n_req;
        r_opsel     <= n_opsel;
        r_text      <= n_text;
        r_place_in  <= n_place_in;
        r_acc_in    <= n_acc_in;
        r_a         <= n_a;
        r_b         <= n_b;
        r_v         <= n_v;
        r_place_out <= n_place_out;
        r_acc_out   <= n_acc_out;
        r_n         <= n_n;
        r_status    <= n_status;
        r_answer    <= n_answer;
        r_out_word  <= n_out_word;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_word;

    `RDC_ASSERT(a_accept_to_check, i_clk, i_rst_n,
        (i_in_valid && o_in_ready) |=> (r_state == S_CHECK), "accepted word did not start")
    `RDC_ASSERT(a_overflow_count, i_clk, i_rst_n,
        (r_state == S_DONE && r_status == ST_OVERFLOW) |-> (r_n == N_W'(OUT_DIGITS)),
        "overflow flagged before all answer digits were used")
    `RDC_ASSERT(a_div_start_idle, i_clk, i_rst_n,
        div_ctrl.start |-> !div_stat.busy, "divider restarted while busy")
    `RDC_ASSERT(a_out_from_done, i_clk, i_rst_n,
        $rose(o_out_valid) |-> ($past(r_state) == S_DONE), "result shown outside done state")

endmodule

/* sv/rdc_divider.sv */
// ----------------------------------------------------------------------------
// rdc_divider
// Shared restoring divider: one quotient bit per cycle against a full-width
// divisor, or several bits per cycle against a divisor below sixteen.
// ----------------------------------------------------------------------------
module rdc_divider
    import rdc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_ctrl        i_ctrl,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [OP_W-1:0]  i_divisor,
    output t_div_stat        o_stat,
    output logic [DIV_W-1:0] o_quotient,
    output logic [OP_W-1:0]  o_remainder
);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic             r_narrow, n_narrow;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DIV_W-1:0] r_quo, n_quo;
    logic [OP_W-1:0]  r_rem, n_rem;
    logic [OP_W-1:0]  r_div, n_div;

    always_comb begin
        logic [OP_W:0]      wrem;
        logic [DIGIT_W:0]   nrem5;
        logic [DIGIT_W-1:0] nrem;
        logic [DIV_W-1:0]   nquo;
        logic               qbit;
        n_busy   = r_busy;
        n_done   = 1'b0;
        n_narrow = r_narrow;
        n_cnt    = r_cnt;
        n_quo    = r_quo;
        n_rem    = r_rem;
        n_div    = r_div;
        wrem     = '0;
        nrem5    = '0;
        nrem     = '0;
        nquo     = '0;
        qbit     = 1'b0;
        if (i_ctrl.start) begin
            n_busy   = 1'b1;
            n_narrow = i_ctrl.narrow;
            n_cnt    = i_ctrl.narrow ? CNT_W'(NARROW_CYC) : CNT_W'(WIDE_CYC);
            n_quo    = i_dividend;
            n_rem    = '0;
            n_div    = i_divisor;
        end else if (r_busy) begin
            if (r_narrow) begin
                nrem = r_rem[DIGIT_W-1:0];
                nquo = r_quo;
                for (int s = 0; s < NARROW_STEPS; s++) begin
                    nrem5 = {nrem, nquo[DIV_W-1]};
                    qbit  = (nrem5 >= {1'b0, r_div[DIGIT_W-1:0]});
                    if (qbit) nrem5 = nrem5 - {1'b0, r_div[DIGIT_W-1:0]};
                    nrem  = nrem5[DIGIT_W-1:0];
                    nquo  = {nquo[DIV_W-2:0], qbit};
                end
                n_rem = OP_W'(nrem);
                n_quo = nquo;
            end else begin
                wrem = {r_rem, r_quo[DIV_W-1]};
                qbit = (wrem >= {1'b0, r_div});
                if (qbit) wrem = wrem - {1'b0, r_div};
                n_rem = wrem[OP_W-1:0];
                n_quo = {r_quo[DIV_W-2:0], qbit};
            end
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_narrow <= n_narrow;
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        r_div    <= n_div;
    end

    assign o_stat.busy  = r_busy;
    assign o_stat.done  = r_done;
    assign o_quotient   = r_quo;
    assign o_remainder  = r_rem;

endmodule

/* tb/sv/tb_radix_digit_calculator.sv */
// ----------------------------------------------------------------------------
// tb_radix_digit_calculator
// Self-checking bench for the radix digit calculator: directed requests at the
// field extremes and every error path, then random well-formed and broken
// requests, with random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_radix_digit_calculator;
    import rdc_pkg::*;

    localparam int IN_DIG  = 9;
    localparam int OUT_DIG = 18;
    localparam int WATCHDOG_LIMIT = 20000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_word  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_word o_out_data;

    radix_digit_calculator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Expected answers, oldest first.
    t_out_word answer_queue[$];
    int        mismatches;
    int        idle_cycles;
    bit        no_idle;       // long stretch with no idling on either side
    bit        hold_off;      // receiver holds off while set
    int        hold_cycles;   // requested hold-off length

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Convert decimal-digit text in base to binary; flag a bad digit or too many digits.
    function automatic bit text_to_bin(input logic [29:0] text, input int base,
                                       output longint unsigned val);
        longint unsigned t, place;
        t = 64'(text);
        place = 1;
        val = 0;
        if (t >= 64'd1000000000) return 1'b0;
        while (t > 0) begin
            if (t % 10 >= base) return 1'b0;
            val += (t % 10) * place;
            place *= base;
            t /= 10;
        end
        return 1'b1;
    endfunction

    // Predict the answer word for one request.
    function automatic t_out_word calc_answer(input t_in_word w);
        t_out_word r;
        longint unsigned a, b, v, text, place;
        int n;
        r.answer = '0;
        r.status = ST_OK;
        if (w.in_base < 2 || w.in_base > 10 || w.out_base < 2 || w.out_base > 10) begin
            r.status = ST_BAD_BASE;
            return r;
        end
        if (!text_to_bin(w.first_operand, w.in_base, a) ||
            !text_to_bin(w.second_operand, w.in_base, b)) begin
            r.status = ST_BAD_DIGIT;
            return r;
        end
        case (w.cmd)
            CMD_ADD: v = a + b;
            CMD_SUB: begin
                if (a < b) begin
                    r.status = ST_NEGATIVE;
                    return r;
                end
                v = a - b;
            end
            CMD_MUL: v = a * b;
            default: begin
                if (b == 0) begin
                    r.status = ST_DIV_ZERO;
                    return r;
                end
                v = a / b;
            end
        endcase
        text = 0;
        place = 1;
        n = 0;
        while (v > 0) begin
            if (n >= OUT_DIG) begin
                text = 0;
                for (int i = 0; i < OUT_DIG; i++) text = text * 10 + (w.out_base - 1);
                r.status = ST_OVERFLOW;
                r.answer = text[59:0];
                return r;
            end
            text += (v % w.out_base) * place;
            v /= w.out_base;
            place *= 10;
            n++;
        end
        r.answer = text[59:0];
        return r;
    endfunction

    // Offer one word; hold it until accepted, then queue its answer.
    // Valid stays high after acceptance unless the sender idles or stops.
    task automatic send_word(input t_in_word w);
        while (!no_idle && $urandom_range(99) < 38) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        answer_queue.push_back(calc_answer(w));
    endtask

    // Drop valid once no further word follows.
    task automatic stop_input();
        i_in_valid <= 1'b0;
    endtask

    // Random operand text in base, up to ndig digits.
    function automatic logic [29:0] rand_text(input int base, input int ndig);
        longint unsigned t;
        t = 0;
        for (int i = 0; i < ndig; i++) t = t * 10 + $urandom_range(base - 1);
        return t[29:0];
    endfunction

    function automatic t_in_word make_word(input logic [1:0] c, input int ib,
                                           input longint unsigned x, input longint unsigned y,
                                           input int ob);
        t_in_word w;
        w.cmd = c;
        w.in_base = ib[3:0];
        w.first_operand = x[29:0];
        w.second_operand = y[29:0];
        w.out_base = ob[3:0];
        return w;
    endfunction

    task automatic test_directed();
        send_word(make_word(CMD_ADD, 10, 0, 0, 10));                    // zero answer
        send_word(make_word(CMD_ADD, 10, 999999999, 999999999, 2));     // overflow
        send_word(make_word(CMD_MUL, 10, 999999999, 999999999, 10));    // largest product, fits without overflow
        send_word(make_word(CMD_MUL, 10, 999999999, 999999999, 3));
        send_word(make_word(CMD_SUB, 2, 101, 110, 10));                 // negative
        send_word(make_word(CMD_SUB, 10, 999999999, 1, 9));
        send_word(make_word(CMD_DIV, 10, 5, 0, 10));                    // divide by zero
        send_word(make_word(CMD_DIV, 10, 999999999, 7, 2));
        send_word(make_word(CMD_DIV, 2, 111111111, 1, 10));
        send_word(make_word(CMD_ADD, 1, 0, 0, 10));                     // bad base
        send_word(make_word(CMD_ADD, 11, 0, 0, 10));
        send_word(make_word(CMD_ADD, 15, 0, 0, 0));
        send_word(make_word(CMD_ADD, 10, 1, 1, 0));
        send_word(make_word(CMD_ADD, 10, 1, 1, 1));
        send_word(make_word(CMD_ADD, 10, 1, 1, 15));
        send_word(make_word(CMD_ADD, 8, 128, 7, 10));                   // bad digit first
        send_word(make_word(CMD_ADD, 8, 7, 19, 10));                    // bad digit second
        send_word(make_word(CMD_ADD, 10, 30'h3FFFFFFF, 1, 10));          // too many digits
        send_word(make_word(CMD_ADD, 10, 1, 1000000000, 10));
        send_word(make_word(CMD_MUL, 2, 111111111, 111111111, 2));
        send_word(make_word(CMD_ADD, 10, 1, 2, 10));
    endtask

    task automatic test_random(input int count);
        t_in_word w;
        int ib, ob, kind;
        for (int k = 0; k < count; k++) begin
            kind = $urandom_range(99);
            ib = $urandom_range(2, 10);
            ob = $urandom_range(2, 10);
            if (kind < 80) begin
                w = make_word(2'($urandom_range(3)), ib,
                              64'(rand_text(ib, $urandom_range(IN_DIG))),
                              64'(rand_text(ib, $urandom_range(IN_DIG))), ob);
            end else begin
                // raw noise over the full field ranges
                w = make_word(2'($urandom_range(3)), $urandom_range(15), 64'($urandom()),
                              64'($urandom()), $urandom_range(15));
            end
            send_word(w);
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 1500;
        hold_off = 1'b1;
        test_random(6);
        stop_input();
        wait (!hold_off);
    endtask

    // Receiver: random readiness, or a counted hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_off) begin
            i_out_ready <= 1'b0;
            if (hold_cycles == 0) hold_off <= 1'b0;
            else hold_cycles <= hold_cycles - 1;
        end else begin
            i_out_ready <= no_idle || ($urandom_range(99) >= 38);
        end
    end

    // Check each accepted answer against the oldest expectation.
    always @(posedge i_clk) begin
        t_out_word exp_word;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (answer_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected answer %0d status %0d",
                                               o_out_data.answer, o_out_data.status);
            end else begin
                exp_word = answer_queue.pop_front();
                if (exp_word.answer !== o_out_data.answer ||
                    exp_word.status !== o_out_data.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d/%0d actual %0d/%0d",
                                 exp_word.answer, exp_word.status,
                                 o_out_data.answer, o_out_data.status);
                end
            end
        end
    end

    // Watchdog: count cycles with no accepted word on either channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL radix_digit_calculator");
            $finish;
        end
    end

    initial begin
        mismatches = 0;
        idle_cycles = 0;
        no_idle = 1'b0;
        hold_off = 1'b0;
        hold_cycles = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random(700);
        no_idle = 1'b1;
        test_random(200);
        no_idle = 1'b0;
        test_random(620);
        stop_input();
        while (answer_queue.size() != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
        if (mismatches == 0 && answer_queue.size() == 0) begin
            $display("PASS radix_digit_calculator");
        end else begin
            $display("FAIL radix_digit_calculator");
        end
        $finish;
    end
endmodule
